// ----- hdl/dpm_pkg.sv -----
// shared types, constants and the decay table function of the density peak block
package dpm_pkg;

    localparam int RESULT_LIMIT = 64;
    localparam int COORD_W      = 16;
    localparam int ENERGY_W     = 16;
    localparam int DENS_W       = 32;
    localparam int CUT_W        = 11;
    localparam int D2_W         = 33;
    localparam int ROOT_W       = 17;
    localparam int DELTA_W      = 16;
    localparam int NUM_W        = 8;
    localparam int CUT_RESET    = 512;

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [ENERGY_W-1:0] e;
        logic [DENS_W-1:0]   dens;
    } t_hit;

    // one cell update request from the sequencer
    typedef struct packed {
        logic rotate;
        logic load;
        logic dens_wr;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DN_PREP,
        ST_DN_MUL,
        ST_DN_SUM,
        ST_DN_CUT,
        ST_DN_SQW,
        ST_DN_LUT,
        ST_DN_ACC,
        ST_DN_ROT,
        ST_DN_WR,
        ST_PK_ROT,
        ST_DL_PREP,
        ST_DL_MUL,
        ST_DL_SUM,
        ST_DL_SQW,
        ST_EMIT
    } t_state;

    // exp(-16y) in q0.16 from y in q1.31, series then four squarings
    function automatic logic [15:0] decay_from_y(input logic [63:0] y);
        logic [63:0] s;
        logic [63:0] term;
        s    = 64'd1 << 31;
        term = 64'd1 << 31;
        term = ((term * y) >> 31);      s = s - term;
        term = ((term * y) >> 31) / 2;  s = s + term;
        term = ((term * y) >> 31) / 3;  s = s - term;
        term = ((term * y) >> 31) / 4;  s = s + term;
        term = ((term * y) >> 31) / 5;  s = s - term;
        term = ((term * y) >> 31) / 6;  s = s + term;
        term = ((term * y) >> 31) / 7;  s = s - term;
        term = ((term * y) >> 31) / 8;  s = s + term;
        term = ((term * y) >> 31) / 9;  s = s - term;
        term = ((term * y) >> 31) / 10; s = s + term;
        s = (s * s) >> 31;
        s = (s * s) >> 31;
        s = (s * s) >> 31;
        s = (s * s) >> 31;
        s = (s + (64'd1 << 14)) >> 15;
        return (s > 64'd65535) ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// ----- hdl/density_peak_measures.sv -----
// top level: hit ring, pair sequencer, density, peak and nearest denser distance
//
// usage
// - input channel (i_valid / o_ready) takes the hits of one event, one item per
//   cycle while loading; the item with i_last_hit high closes the event
// - up to min(MAX_HITS, 64) hits are stored, later hits of the event are dropped,
//   but their last flag still closes the event
// - after the closing item the block computes, then emits one result item per
//   stored hit in load order on o_valid / i_ready; end_of_event marks the final one
// - configuration channel (i_cfg_valid / o_cfg_ready) writes radius_cut; it is
//   always ready and must only be written while the block is idle
// - steps: a density row visits every ring cell; a cell past the stored hits only
//   rotates, one outside the cut forms its squared distance first, one inside it
//   also takes a root in the shared square root unit, reads the decay table and
//   accumulates; a density write ends the row; the peak search rotates once round
//   the ring; a delta row finds the least squared distance to a denser hit, roots
//   it if found and emits; one event at a time, the next loads after the last result
// - the output register lets the last result wait while the next event loads
// - reset (synchronous, active low) empties the event and sets radius_cut to 512;
//   a stalled receiver simply holds the sequencer in its emit step
module density_peak_measures #(
    parameter int MAX_HITS          = 256,
    parameter int DECAY_TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dpm_pkg::CUT_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [dpm_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [dpm_pkg::COORD_W-1:0] i_pos_y,
    input  logic [dpm_pkg::ENERGY_W-1:0]  i_hit_energy,
    input  logic                          i_last_hit,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dpm_pkg::NUM_W-1:0]     o_hit_number,
    output logic [dpm_pkg::DENS_W-1:0]    o_local_density,
    output logic [dpm_pkg::DELTA_W-1:0]   o_nearest_denser_distance,
    output logic                          o_is_peak,
    output logic                          o_end_of_event
);
    import dpm_pkg::*;

    // ring size and index widths
    localparam int CAP = (MAX_HITS < RESULT_LIMIT) ? MAX_HITS : RESULT_LIMIT;
    localparam int IW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);
    localparam int TW  = $clog2(DECAY_TABLE_DEPTH);
    localparam int SW  = ROOT_W + 13;

    // decay table, built at elaboration
    logic [15:0] w_decay [DECAY_TABLE_DEPTH];
    for (genvar g = 0; g < DECAY_TABLE_DEPTH; g++) begin : g_decay
        localparam logic [63:0] Y = ((64'd4 << 31) * 64'(g) / DECAY_TABLE_DEPTH) >> 4;
        localparam logic [15:0] ENTRY = decay_from_y(Y);
        assign w_decay[g] = ENTRY;
    end

    // control state
    t_state r_state, n_state;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_n;
    logic [IW-1:0]     r_i;
    logic [IW-1:0]     r_j;
    logic [IW-1:0]     r_peak;
    logic [CUT_W-1:0]  r_cut;
    logic              r_o_valid;

    // datapath registers
    logic [COORD_W-1:0]   r_xi, r_yi;
    logic [DENS_W-1:0]    r_di;
    logic [31:0]          r_dx2, r_dy2;
    logic [D2_W-1:0]      r_d2;
    logic [D2_W-1:0]      r_best;
    logic                 r_found;
    logic [2*CUT_W-1:0]   r_cut2;
    logic [TW-1:0]        r_idx;
    logic [31:0]          r_prod;
    logic [DENS_W-1:0]    r_acc;
    logic [DENS_W-1:0]    r_pk_best;
    logic [DELTA_W-1:0]   r_delta;
    logic [NUM_W-1:0]     r_o_num;
    logic [DENS_W-1:0]    r_o_dens;
    logic [DELTA_W-1:0]   r_o_delta;
    logic                 r_o_peak;
    logic                 r_o_eoe;

    // ring of cells, head is cell 0
    t_hit      w_cell [CAP];
    t_hit      w_load_hit;
    t_hit      w_head;
    t_hit      w_sel;
    logic      w_rotate;
    logic      w_accept;
    logic      w_store;
    logic      w_dens_wr;

    logic w_j_live;
    logic w_dl_hit;
    logic w_in_cut;
    logic w_j_last;
    logic w_i_last;
    logic w_out_free;
    logic w_sq_start;
    logic [D2_W-1:0] w_sq_value;
    logic w_sq_done;
    logic [ROOT_W-1:0] w_sq_root;

    // squared distance from hit i to the head
    logic signed [COORD_W:0]     w_dx, w_dy;
    logic signed [2*COORD_W+1:0] w_px, w_py;
    logic [D2_W-1:0]             w_d2sum;
    logic                        w_closer;
    logic [D2_W-1:0]             w_best_next;
    logic [SW-1:0]               w_scaled;
    logic [32:0]                 w_acc_sum;

    assign w_accept   = i_valid && (r_state == ST_LOAD);
    assign w_store    = w_accept && (r_cnt < CW'(CAP));
    assign w_load_hit = '{x: i_pos_x, y: i_pos_y, e: i_hit_energy, dens: '0};
    assign w_head     = w_cell[0];
    assign w_sel      = w_cell[r_i];
    assign w_rotate   = (r_state == ST_DN_ROT) || (r_state == ST_PK_ROT)
                      || ((r_state == ST_DL_MUL) && !w_dl_hit)
                      || (r_state == ST_DL_SUM)
                      || ((r_state == ST_DN_MUL) && !w_j_live)
                      || ((r_state == ST_DN_CUT) && !w_in_cut);
    assign w_dens_wr  = (r_state == ST_DN_WR);

    assign w_j_live   = CW'(r_j) < r_n;
    assign w_dl_hit   = w_j_live && (r_i != r_peak) && (w_head.dens > r_di);
    assign w_in_cut   = r_d2 <= D2_W'(r_cut2);
    assign w_j_last   = r_j == IW'(CAP - 1);
    assign w_i_last   = (CW'(r_i) + CW'(1)) == r_n;
    assign w_out_free = !r_o_valid || i_ready;

    for (genvar k = 0; k < CAP; k++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl = '{rotate:  w_rotate,
                         load:    w_store && (r_cnt[IW-1:0] == IW'(k)),
                         dens_wr: w_dens_wr && (r_i == IW'(k))};
        dpm_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_next (w_cell[(k + 1) % CAP]),
            .i_load (w_load_hit),
            .i_dens (r_acc),
            .o_hit  (w_cell[k])
        );
    end

    // shared square root unit
    assign w_sq_start = ((r_state == ST_DN_CUT) && w_in_cut)
                      || ((r_state == ST_DL_MUL) && w_j_last && !w_dl_hit && r_found)
                      || ((r_state == ST_DL_SUM) && w_j_last && (r_found || w_closer));
    assign w_sq_value = (r_state == ST_DN_CUT) ? r_d2 : w_best_next;

    dpm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (w_sq_value),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    always_comb begin
        w_dx        = $signed({r_xi[COORD_W-1], r_xi}) - $signed({w_head.x[COORD_W-1], w_head.x});
        w_dy        = $signed({r_yi[COORD_W-1], r_yi}) - $signed({w_head.y[COORD_W-1], w_head.y});
        w_px        = w_dx * w_dx;
        w_py        = w_dy * w_dy;
        w_d2sum     = D2_W'(r_dx2) + D2_W'(r_dy2);
        w_closer    = !r_found || (w_d2sum < r_best);
        w_best_next = ((r_state == ST_DL_SUM) && w_closer) ? w_d2sum : r_best;
        w_scaled    = SW'(w_sq_root) * SW'(DECAY_TABLE_DEPTH);
        w_acc_sum   = {1'b0, r_acc} + {1'b0, r_prod};
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:    if (w_accept && i_last_hit) n_state = ST_DN_PREP;
            ST_DN_PREP: n_state = ST_DN_MUL;
            ST_DN_MUL:  n_state = w_j_live ? ST_DN_SUM
                                 : (w_j_last ? ST_DN_WR : ST_DN_MUL);
            ST_DN_SUM:  n_state = ST_DN_CUT;
            ST_DN_CUT:  n_state = w_in_cut ? ST_DN_SQW
                                 : (w_j_last ? ST_DN_WR : ST_DN_MUL);
            ST_DN_SQW:  if (w_sq_done) n_state = ST_DN_LUT;
            ST_DN_LUT:  n_state = ST_DN_ACC;
            ST_DN_ACC:  n_state = ST_DN_ROT;
            ST_DN_ROT:  n_state = w_j_last ? ST_DN_WR : ST_DN_MUL;
            ST_DN_WR:   n_state = w_i_last ? ST_PK_ROT : ST_DN_PREP;
            ST_PK_ROT:  if (w_j_last) n_state = ST_DL_PREP;
            ST_DL_PREP: n_state = ST_DL_MUL;
            ST_DL_MUL: begin
                if (w_dl_hit) begin
                    n_state = ST_DL_SUM;
                end else if (w_j_last) begin
                    n_state = r_found ? ST_DL_SQW : ST_EMIT;
                end
            end
            ST_DL_SUM: begin
                if (w_j_last) begin
                    n_state = ST_DL_SQW;
                end else begin
                    n_state = ST_DL_MUL;
                end
            end
            ST_DL_SQW:  if (w_sq_done) n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = w_i_last ? ST_LOAD : ST_DL_PREP;
                end
            end
            default:    n_state = ST_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_cnt     <= '0;
            r_cut     <= CUT_W'(CUT_RESET);
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cut <= i_cfg_data;
            end
            if (w_store) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if ((r_state == ST_EMIT) && w_out_free && w_i_last) begin
                r_cnt <= '0;
            end
            if ((r_state == ST_EMIT) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_rotate) begin
            r_j <= (w_j_last) ? '0 : r_j + IW'(1);
        end
        case (r_state)
            ST_LOAD: begin
                r_i    <= '0;
                r_j    <= '0;
                r_cut2 <= r_cut * r_cut;
                if (w_accept) begin
                    r_n <= w_store ? r_cnt + CW'(1) : r_cnt;
                end
            end
            ST_DN_PREP: begin
                r_xi  <= w_sel.x;
                r_yi  <= w_sel.y;
                r_acc <= '0;
            end
            ST_DN_MUL: begin
                r_dx2 <= w_px[31:0];
                r_dy2 <= w_py[31:0];
            end
            ST_DN_SUM: r_d2 <= w_d2sum;
            ST_DN_SQW: begin
                if (w_scaled[SW-1:10] > SW'(DECAY_TABLE_DEPTH - 1)) begin
                    r_idx <= TW'(DECAY_TABLE_DEPTH - 1);
                end else begin
                    r_idx <= w_scaled[10 +: TW];
                end
            end
            ST_DN_LUT: r_prod <= w_head.e * w_decay[r_idx];
            ST_DN_ACC: r_acc  <= w_acc_sum[32] ? '1 : w_acc_sum[31:0];
            ST_DN_WR: begin
                r_i <= w_i_last ? '0 : r_i + IW'(1);
            end
            ST_PK_ROT: begin
                if (w_j_live && ((r_j == '0) || (w_head.dens > r_pk_best))) begin
                    r_peak    <= r_j;
                    r_pk_best <= w_head.dens;
                end
            end
            ST_DL_PREP: begin
                r_xi    <= w_sel.x;
                r_yi    <= w_sel.y;
                r_di    <= w_sel.dens;
                r_found <= 1'b0;
                r_delta <= '1;
            end
            ST_DL_MUL: begin
                r_dx2 <= w_px[31:0];
                r_dy2 <= w_py[31:0];
            end
            ST_DL_SUM: begin
                r_best  <= w_best_next;
                r_found <= 1'b1;
            end
            ST_DL_SQW: begin
                if (w_sq_done) begin
                    r_delta <= (w_sq_root[ROOT_W-1]) ? '1 : w_sq_root[DELTA_W-1:0];
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    r_o_num   <= NUM_W'(r_i);
                    r_o_dens  <= r_di;
                    r_o_delta <= r_delta;
                    r_o_peak  <= r_i == r_peak;
                    r_o_eoe   <= w_i_last;
                    r_i       <= w_i_last ? '0 : r_i + IW'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_cfg_ready               = 1'b1;
    assign o_ready                   = (r_state == ST_LOAD);
    assign o_valid                   = r_o_valid;
    assign o_hit_number              = r_o_num;
    assign o_local_density           = r_o_dens;
    assign o_nearest_denser_distance = r_o_delta;
    assign o_is_peak                 = r_o_peak;
    assign o_end_of_event            = r_o_eoe;
endmodule

// ----- hdl/dpm_cell.sv -----
// one storage cell of the hit ring
module dpm_cell (
    input  logic              i_clk,
    input  dpm_pkg::t_cell_ctl i_ctl,
    input  dpm_pkg::t_hit     i_next,
    input  dpm_pkg::t_hit     i_load,
    input  logic [dpm_pkg::DENS_W-1:0] i_dens,
    output dpm_pkg::t_hit     o_hit
);
    import dpm_pkg::*;

    t_hit r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate) begin
            r_hit <= i_next;
        end else if (i_ctl.load) begin
            r_hit <= i_load;
        end else if (i_ctl.dens_wr) begin
            r_hit.dens <= i_dens;
        end
    end

    assign o_hit = r_hit;
endmodule

// ----- hdl/dpm_isqrt.sv -----
// bit serial integer square root, one result bit per cycle
module dpm_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dpm_pkg::D2_W-1:0]   i_value,
    output logic                       o_done,
    output logic [dpm_pkg::ROOT_W-1:0] o_root
);
    import dpm_pkg::*;

    logic [2*ROOT_W-1:0] r_v, n_v;
    logic [ROOT_W+1:0]   r_rem, n_rem;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [4:0]          r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [ROOT_W+1:0]   w_rem2;
    logic [ROOT_W+1:0]   w_trial;

    always_comb begin
        w_rem2  = {r_rem[ROOT_W-1:0], r_v[2*ROOT_W-1 -: 2]};
        w_trial = {r_root, 2'b01};
        n_v     = {r_v[2*ROOT_W-3:0], 2'b00};
        if (w_rem2 >= w_trial) begin
            n_rem  = w_rem2 - w_trial;
            n_root = {r_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = w_rem2;
            n_root = {r_root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= {1'b0, i_value};
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_v    <= n_v;
                r_rem  <= n_rem;
                r_root <= n_root;
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ----- bench/tb.sv -----
// testbench of density_peak_measures: directed and random events checked against a predictor
`timescale 1ns / 1ps

module tb;
    import dpm_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int TABLE_LEN  = 256;
    localparam int CYCLE_CAP  = 4000000;
    localparam int TAIL_WAIT  = 64;

    // one expected result item
    typedef struct {
        logic [NUM_W-1:0]   num;
        logic [DENS_W-1:0]  dens;
        logic [DELTA_W-1:0] delta;
        logic               peak;
        logic               eoe;
    } t_measure;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CUT_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic signed [COORD_W-1:0] i_pos_x = '0;
    logic signed [COORD_W-1:0] i_pos_y = '0;
    logic [ENERGY_W-1:0] i_hit_energy = '0;
    logic i_last_hit = 1'b0;
    logic i_ready = 1'b0;
    logic o_cfg_ready;
    logic o_ready;
    logic o_valid;
    logic [NUM_W-1:0] o_hit_number;
    logic [DENS_W-1:0] o_local_density;
    logic [DELTA_W-1:0] o_nearest_denser_distance;
    logic o_is_peak;
    logic o_end_of_event;

    density_peak_measures u_dut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_cfg_valid               (i_cfg_valid),
        .o_cfg_ready               (o_cfg_ready),
        .i_cfg_data                (i_cfg_data),
        .i_valid                   (i_valid),
        .o_ready                   (o_ready),
        .i_pos_x                   (i_pos_x),
        .i_pos_y                   (i_pos_y),
        .i_hit_energy              (i_hit_energy),
        .i_last_hit                (i_last_hit),
        .o_valid                   (o_valid),
        .i_ready                   (i_ready),
        .o_hit_number              (o_hit_number),
        .o_local_density           (o_local_density),
        .o_nearest_denser_distance (o_nearest_denser_distance),
        .o_is_peak                 (o_is_peak),
        .o_end_of_event            (o_end_of_event)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state: the open event, the radius and the decay rom
    logic signed [COORD_W-1:0] ev_x [CAPACITY];
    logic signed [COORD_W-1:0] ev_y [CAPACITY];
    logic [ENERGY_W-1:0]       ev_e [CAPACITY];
    logic [DENS_W-1:0]         ev_dens [CAPACITY];
    int                        ev_count = 0;
    logic [CUT_W-1:0]          cut_reg = CUT_W'(CUT_RESET);
    logic [15:0]               decay_rom [TABLE_LEN];

    t_measure pending_measures [$];
    int  errors = 0;
    int  cycles = 0;
    int  items_sent = 0;
    int  events_sent = 0;
    int  results_seen = 0;
    int  cfg_writes = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;

    // exp(-4i/len) in q0.16: series for exp(-x/16), then raised to the 16th power
    function automatic logic [15:0] decay_value(input int idx);
        logic [63:0] y, s, term;
        y = (((64'd4 << 31) * idx) / TABLE_LEN) >> 4;
        s = 64'd1 << 31;
        term = 64'd1 << 31;
        for (int k = 1; k <= 10; k++) begin
            term = ((term * y) >> 31) / k;
            if (k % 2 == 1) s = s - term;
            else s = s + term;
        end
        for (int k = 0; k < 4; k++) s = (s * s) >> 31;
        s = (s + (64'd1 << 14)) >> 15;
        return (s > 64'd65535) ? 16'hFFFF : s[15:0];
    endfunction

    // floor square root, bit by bit from the top
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r, c;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    function automatic longint unsigned pair_dist2(input int a, input int b);
        longint dx, dy;
        dx = longint'(ev_x[a]) - longint'(ev_x[b]);
        dy = longint'(ev_y[a]) - longint'(ev_y[b]);
        return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    // densities, peak and nearest denser distance of the closed event
    task automatic predict_event_measures();
        longint unsigned cut2, d2, acc, idx, best;
        int peak;
        bit found;
        t_measure m;
        cut2 = longint'(cut_reg) * longint'(cut_reg);
        for (int i = 0; i < ev_count; i++) begin
            acc = 0;
            for (int j = 0; j < ev_count; j++) begin
                d2 = pair_dist2(i, j);
                if (d2 <= cut2) begin
                    idx = (floor_root(d2) * TABLE_LEN) >> 10;
                    if (idx > TABLE_LEN - 1) idx = TABLE_LEN - 1;
                    acc += longint'(ev_e[j]) * longint'(decay_rom[idx]);
                    if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
                end
            end
            ev_dens[i] = acc[31:0];
        end
        peak = 0;
        for (int i = 1; i < ev_count; i++)
            if (ev_dens[i] > ev_dens[peak]) peak = i;
        for (int i = 0; i < ev_count; i++) begin
            m.delta = 16'hFFFF;
            if (i != peak) begin
                found = 1'b0;
                best = 0;
                for (int j = 0; j < ev_count; j++) begin
                    if (ev_dens[j] > ev_dens[i]) begin
                        d2 = pair_dist2(i, j);
                        if (!found || d2 < best) begin
                            best = d2;
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    best = floor_root(best);
                    m.delta = (best > 65535) ? 16'hFFFF : best[15:0];
                end
            end
            m.num  = i[NUM_W-1:0];
            m.dens = ev_dens[i];
            m.peak = (i == peak);
            m.eoe  = (i + 1 == ev_count);
            pending_measures = {pending_measures, m};
        end
        ev_count = 0;
    endtask

    // mostly short gaps, a few long ones, none while no_idle is set
    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one hit item and update the predictor once it is taken
    task automatic send_hit(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic [15:0] e, input logic last);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_pos_x      <= x;
        i_pos_y      <= y;
        i_hit_energy <= e;
        i_last_hit   <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        if (ev_count < CAPACITY) begin
            ev_x[ev_count] = x;
            ev_y[ev_count] = y;
            ev_e[ev_count] = e;
            ev_count++;
        end
        if (last) begin
            events_sent++;
            predict_event_measures();
        end
    endtask

    // wait for every pending result, then let the block settle
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_measures.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [CUT_W-1:0] cut);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cut;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cut_reg = cut;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // one event of n hits around a center, offsets within +-spread
    task automatic send_cluster(input int n, input int spread, input bit wide);
        int cx, cy;
        logic signed [15:0] x, y;
        logic [15:0] e;
        cx = int'($urandom_range(0, 60000)) - 30000;
        cy = int'($urandom_range(0, 60000)) - 30000;
        for (int k = 0; k < n; k++) begin
            if (wide) begin
                x = 16'($urandom);
                y = 16'($urandom);
            end else begin
                x = 16'(cx + int'($urandom_range(0, 2 * spread)) - spread);
                y = 16'(cy + int'($urandom_range(0, 2 * spread)) - spread);
            end
            e = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
            send_hit(x, y, e, k == n - 1);
        end
    endtask

    // result side: random stalls, field by field comparison
    always @(posedge i_clk) begin
        t_measure m;
        int r;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_measures.size() == 0) begin
                $display("%0t unexpected result item hit_number=%0d", $time, o_hit_number);
                errors++;
            end else begin
                m = pending_measures.pop_front();
                if (o_hit_number !== m.num) begin
                    $display("%0t hit_number exp %0d got %0d", $time, m.num, o_hit_number);
                    errors++;
                end
                if (o_local_density !== m.dens) begin
                    $display("%0t local_density exp %0d got %0d", $time, m.dens,
                             o_local_density);
                    errors++;
                end
                if (o_nearest_denser_distance !== m.delta) begin
                    $display("%0t nearest_denser_distance exp %0d got %0d", $time, m.delta,
                             o_nearest_denser_distance);
                    errors++;
                end
                if (o_is_peak !== m.peak) begin
                    $display("%0t is_peak exp %0b got %0b", $time, m.peak, o_is_peak);
                    errors++;
                end
                if (o_end_of_event !== m.eoe) begin
                    $display("%0t end_of_event exp %0b got %0b", $time, m.eoe, o_end_of_event);
                    errors++;
                end
            end
        end
        if (no_idle) i_ready <= 1'b1;
        else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            i_ready <= (r < 85);
            if (r >= 97) stall_left <= $urandom_range(10, 40);
        end
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        if (cycles > CYCLE_CAP) begin
            $display("density_peak_measures test failed");
            $finish;
        end
    end

    // single hit, far corners, saturated density, ties and the cut boundary
    task automatic test_directed();
        send_hit(16'sd0, 16'sd0, 16'd1, 1'b1);
        send_hit(-16'sd32768, -16'sd32768, 16'hFFFF, 1'b0);
        send_hit(16'sd32767, 16'sd32767, 16'h0000, 1'b1);
        for (int k = 0; k < 3; k++) send_hit(16'sd100, -16'sd100, 16'hFFFF, k == 2);
        send_hit(16'sd0, 16'sd0, 16'd500, 1'b0);
        send_hit(16'sd512, 16'sd0, 16'd900, 1'b0);
        send_hit(16'sd0, 16'sd513, 16'd700, 1'b0);
        send_hit(-16'sd1, -16'sd1, 16'd500, 1'b1);
        send_hit(16'sd0, 16'sd0, 16'd0, 1'b0);
        send_hit(16'sd5, 16'sd5, 16'd0, 1'b1);
    endtask

    // more hits than the event holds, last flag on a dropped hit
    task automatic test_capacity();
        for (int k = 0; k < CAPACITY + 2; k++)
            send_hit(16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)),
                     16'($urandom), k == CAPACITY + 1);
    endtask

    // radius extremes: zero, one, 1024 and the top of range 2047, then 300 and 700
    task automatic test_radius();
        int cuts [6] = '{0, 1, 1024, 2047, 300, 700};
        foreach (cuts[c]) begin
            write_radius(CUT_W'(cuts[c]));
            send_hit(16'sd10, 16'sd10, 16'd1000, 1'b0);
            send_hit(16'sd10, 16'sd10, 16'd2000, 1'b0);
            send_cluster($urandom_range(2, 4), cuts[c] + 2, 1'b0);
        end
        write_radius(CUT_W'(CUT_RESET));
    endtask

    // the sender holds off until every result is back
    task automatic test_hold_off();
        send_cluster(5, 400, 1'b0);
        drain_results();
        send_cluster(3, 400, 1'b0);
    endtask

    // random events: mostly tight clusters, some scattered, radius changed now and then
    task automatic test_random();
        int r;
        while (items_sent < 430) begin
            r = $urandom_range(0, 99);
            no_idle = (r < 12);
            if (r < 8) write_radius(CUT_W'($urandom_range(0, 2047)));
            else if (r < 14) write_radius(CUT_W'($urandom_range(200, 1024)));
            if (r < 6) send_cluster($urandom_range(10, 16), $urandom_range(100, 1500), 1'b0);
            else if (r < 18) send_cluster($urandom_range(1, 6), 0, 1'b1);
            else send_cluster($urandom_range(1, 7), $urandom_range(16, 1200), 1'b0);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < TABLE_LEN; i++) decay_rom[i] = decay_value(i);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity();
        test_radius();
        test_hold_off();
        test_random();
        drain_results();
        $display("%0d hit items in %0d events, %0d result items, %0d radius writes",
                 items_sent, events_sent, results_seen, cfg_writes);
        $display("covered far corners, saturation, ties, dropped hits and radius 0..2047");
        if (errors == 0 && pending_measures.size() == 0) begin
            $display("density_peak_measures test passed");
        end else begin
            $display("density_peak_measures test failed");
        end
        $finish;
    end

endmodule
